>>> src/kbio_pkg.sv
// Shared types and constants for the keyboard and serial I/O port block.
`default_nettype none
package kbio_pkg;

    // Item kinds
    localparam logic [1:0] KIND_PORT_WRITE = 2'd0;
    localparam logic [1:0] KIND_PORT_READ  = 2'd1;
    localparam logic [1:0] KIND_KEY_EVENT  = 2'd2;

    // Port addresses
    localparam logic [7:0] PORT_KBD    = 8'd0;
    localparam logic [7:0] PORT_SERIAL = 8'd1;
    localparam logic [7:0] PORT_STATUS = 8'd2;

    // Port-0 write bit positions
    localparam int P0_KBD_CLOCK_BIT = 0;
    localparam int P0_KBD_RESET_BIT = 1;
    localparam int P0_TAPE_LED_BIT  = 4;

    // Status word bits
    localparam logic [7:0] ST_RX_READY = 8'h80;
    localparam logic [7:0] ST_TX_EMPTY = 8'h40;

    // Keyboard matrix geometry
    localparam int          KEY_ROWS     = 8;
    localparam int          KEY_ROW_W    = 7;
    localparam logic [2:0]  KEY_COL_NONE = 3'd7;
    localparam logic [2:0]  SCAN_CLEAR   = 3'd0;
    localparam logic [7:0]  PREV_ON_RST  = 8'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] port_number;
        logic [7:0] write_value;
        logic [2:0] key_row;
        logic [2:0] key_column;
        logic       key_down;
        logic [7:0] rx_byte;
        logic       rx_present;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
        logic       led_out;
    } t_result;

endpackage
`default_nettype wire

>>> src/kbio_exec.sv
// Port state (key matrix, scan counter, tape LED) and per-request result logic.
`default_nettype none
module kbio_exec (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  kbio_pkg::t_item  i_item,
    input  wire              i_led_force,
    output kbio_pkg::t_result o_result
);
    import kbio_pkg::*;

    logic [KEY_ROW_W-1:0] r_key_matrix [KEY_ROWS];
    logic [KEY_ROW_W-1:0] n_key_row;
    logic [2:0]           r_scan_row, n_scan_row;
    logic [7:0]           r_prev_p0, n_prev_p0;
    logic                 r_led_lit, n_led_lit;
    logic                 key_wr;
    logic [7:0]           rise;
    logic                 rx_ok;

    // Compute next state and the result of the current request
    always_comb begin
        n_scan_row = r_scan_row;
        n_prev_p0  = r_prev_p0;
        n_led_lit  = r_led_lit;
        n_key_row  = r_key_matrix[i_item.key_row];
        key_wr     = 1'b0;
        rise       = ~r_prev_p0 & i_item.write_value;
        rx_ok      = i_item.rx_present & r_led_lit;
        o_result   = '0;

        case (i_item.kind)
            KIND_PORT_WRITE: begin
                if (i_item.port_number == PORT_KBD) begin
                    n_prev_p0 = i_item.write_value;
                    if (i_item.write_value[P0_KBD_RESET_BIT]) begin
                        n_scan_row = SCAN_CLEAR;
                        n_prev_p0  = PREV_ON_RST;
                    end else if (rise[P0_KBD_CLOCK_BIT]) begin
                        n_scan_row = r_scan_row + 3'd1;
                    end
                    n_led_lit = i_item.write_value[P0_TAPE_LED_BIT] | i_led_force;
                end else if (i_item.port_number == PORT_SERIAL) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = i_item.write_value;
                end
            end
            KIND_PORT_READ: begin
                if (i_item.port_number == PORT_KBD) begin
                    o_result.read_data = {1'b1, ~r_key_matrix[r_scan_row]};
                end else if (i_item.port_number == PORT_SERIAL) begin
                    if (rx_ok) begin
                        o_result.read_data = i_item.rx_byte;
                        o_result.rx_taken  = 1'b1;
                    end
                end else if (i_item.port_number == PORT_STATUS) begin
                    o_result.read_data = ST_TX_EMPTY | (rx_ok ? ST_RX_READY : 8'd0);
                end
            end
            KIND_KEY_EVENT: begin
                if (i_item.key_column != KEY_COL_NONE) begin
                    key_wr = 1'b1;
                    n_key_row[i_item.key_column] = i_item.key_down;
                end
            end
            default: begin
            end
        endcase

        o_result.led_out = n_led_lit;
    end

    // Commit state when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_ROWS; i++) begin
                r_key_matrix[i] <= '0;
            end
            r_scan_row <= '0;
            r_prev_p0  <= '0;
            r_led_lit  <= 1'b0;
        end else if (i_fire) begin
            if (key_wr) begin
                r_key_matrix[i_item.key_row] <= n_key_row;
            end
            r_scan_row <= n_scan_row;
            r_prev_p0  <= n_prev_p0;
            r_led_lit  <= n_led_lit;
        end
    end

endmodule
`default_nettype wire

>>> src/keyboard_uart_io_ports.sv
// Top level of the keyboard and serial I/O port block: request and result registers.
//
//   Channel   Direction  Handshake            Payload
//   request   in         i_valid / o_stall    i_kind .. i_rx_present
//   result    out        o_valid / i_stall    o_read_data .. o_led_out
//   config    in         i_cfg_we             i_cfg_wdata (tape LED force)
//
// A request is registered, evaluated combinationally and lands in the result
// register; one request per cycle while the result is not stalled.
// Synchronous active-low reset clears the key matrix, scan counter, previous
// port-0 value, tape LED, force bit and both valid flags.
// A stalled result holds; the request register still fills behind it.
`default_nettype none
module keyboard_uart_io_ports (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [1:0] i_kind,
    input  wire  [7:0] i_port_number,
    input  wire  [7:0] i_write_value,
    input  wire  [2:0] i_key_row,
    input  wire  [2:0] i_key_column,
    input  wire        i_key_down,
    input  wire  [7:0] i_rx_byte,
    input  wire        i_rx_present,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_read_data,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_rx_taken,
    output logic       o_led_out,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata
);
    import kbio_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result exec_result;
    logic    r_led_force;
    logic    advance;
    logic    fire;
    logic    take;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign take    = i_valid && !o_stall;

    // Hold the force bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_force <= 1'b0;
        end else if (i_cfg_we) begin
            r_led_force <= i_cfg_wdata;
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.kind        <= i_kind;
            r_in.port_number <= i_port_number;
            r_in.write_value <= i_write_value;
            r_in.key_row     <= i_key_row;
            r_in.key_column  <= i_key_column;
            r_in.key_down    <= i_key_down;
            r_in.rx_byte     <= i_rx_byte;
            r_in.rx_present  <= i_rx_present;
        end
    end

    kbio_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_led_force (r_led_force),
        .o_result    (exec_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= exec_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_tx_valid  = r_out.tx_valid;
    assign o_tx_byte   = r_out.tx_byte;
    assign o_rx_taken  = r_out.rx_taken;
    assign o_led_out   = r_out.led_out;

endmodule
`default_nettype wire
